// File: hdl/sst_pkg.sv
// Shared types, constants and lookup functions of the script source tokenizer.
`default_nettype none
package sst_pkg;

	localparam int KW_COUNT = 61;
	localparam int KW_TEXT_BYTES = 11;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_PUNCT,
		MODE_LINE,
		MODE_BLOCK,
		MODE_STAR,
		MODE_NAME,
		MODE_NUM,
		MODE_CARET,
		MODE_STR,
		MODE_ESC
	} lex_mode_t;

	localparam logic [1:0] KIND_TOKEN = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;
	localparam logic [1:0] KIND_END   = 2'd3;

	localparam logic [6:0] CLASS_NAME    = 7'd0;
	localparam logic [6:0] CLASS_NUMBER  = 7'd1;
	localparam logic [6:0] CLASS_STRING  = 7'd2;
	localparam logic [6:0] CLASS_PUNCT   = 7'd3;
	localparam logic [6:0] CLASS_KW_BASE = 7'd4;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
	localparam logic [2:0] ERR_NEWLINE    = 3'd2;
	localparam logic [2:0] ERR_ESCAPE     = 3'd3;
	localparam logic [2:0] ERR_SYMBOL     = 3'd4;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic REG_START_LINE   = 1'b0;
	localparam logic REG_START_OFFSET = 1'b1;

	localparam logic [5:0] PUNCT_NONE = 6'd63;
	// Single characters up to this code may combine with a second character.
	localparam logic [5:0] PUNCT_LAST_PAIRABLE = 6'd23;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} src_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [6:0]  token_class;
		logic [5:0]  punct_code;
		logic [31:0] start_offset_res;
		logic [31:0] token_length;
		logic [31:0] line_number;
		logic [2:0]  error_code;
		logic [7:0]  char_value;
		logic        last_of_run;
	} tok_item_t;

	// Words are right-justified: the last character sits in the low byte.
	localparam logic [8*KW_TEXT_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
		"abstract", "anonymous", "as",
		"branching", "break", "byval",
		"case", "catch", "class", "coerce", "const", "continue",
		"default", "delegate", "do",
		"else", "enum", "explicit", "extends",
		"false", "final", "finally", "for", "foreach", "function",
		"if", "implements", "in", "intercept", "interface", "is",
		"local", "localized",
		"mustbeconst", "mustberef",
		"native", "namespace", "new", "notnull", "null",
		"private", "promote", "property", "protected", "public",
		"resource", "return",
		"static", "struct", "switch",
		"this", "throw", "try", "true", "tuple", "typedef", "typeof",
		"using",
		"virtual", "void",
		"while"
	};

	function automatic tok_item_t make_res(logic [1:0] kind, logic [6:0] cls,
		logic [5:0] pc, logic [31:0] off, logic [31:0] len, logic [31:0] line,
		logic [2:0] err, logic [7:0] ch);
		tok_item_t r;
		r.result_kind      = kind;
		r.token_class      = cls;
		r.punct_code       = pc;
		r.start_offset_res = off;
		r.token_length     = len;
		r.line_number      = line;
		r.error_code       = err;
		r.char_value       = ch;
		r.last_of_run      = 1'b0;
		return r;
	endfunction

	function automatic logic [5:0] punct_single(logic [7:0] a);
		logic [5:0] r;
		unique case (a)
			":": r = 6'd1;
			"<": r = 6'd3;
			">": r = 6'd5;
			"=": r = 6'd7;
			"!": r = 6'd9;
			"+": r = 6'd12;
			"-": r = 6'd15;
			"*": r = 6'd17;
			"/": r = 6'd19;
			"&": r = 6'd21;
			"|": r = 6'd23;
			";": r = 6'd24;
			",": r = 6'd25;
			"{": r = 6'd26;
			"}": r = 6'd27;
			"[": r = 6'd28;
			"]": r = 6'd29;
			"(": r = 6'd30;
			")": r = 6'd31;
			".": r = 6'd32;
			"?": r = 6'd33;
			default: r = PUNCT_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] punct_pair(logic [7:0] a, logic [7:0] b);
		logic [5:0] r;
		r = PUNCT_NONE;
		unique case (a)
			":": if (b == "<") r = 6'd0;
			"<": if (b == "=") r = 6'd2;
			">": if (b == "=") r = 6'd4;
			"=": if (b == "=") r = 6'd6;
			"!": if (b == "=") r = 6'd8;
			"+": begin
				if (b == "=") r = 6'd10;
				else if (b == "+") r = 6'd11;
			end
			"-": begin
				if (b == "=") r = 6'd13;
				else if (b == "-") r = 6'd14;
			end
			"*": if (b == "=") r = 6'd16;
			"/": if (b == "=") r = 6'd18;
			"&": if (b == "&") r = 6'd20;
			"|": if (b == "|") r = 6'd22;
			default: r = PUNCT_NONE;
		endcase
		return r;
	endfunction

	// Parallel compare of the stored name against every reserved word.
	function automatic logic [6:0] kw_class(logic [KW_TEXT_BYTES-1:0][7:0] text,
		logic [3:0] len, logic eligible);
		logic [6:0] cls;
		logic found;
		logic hit;
		int n;
		cls = CLASS_NAME;
		found = 1'b0;
		for (int i = 0; i < KW_COUNT; i++) begin
			n = 0;
			for (int k = 0; k < KW_TEXT_BYTES; k++) begin
				if (KW_TEXT[i][8*k +: 8] != 8'd0) n = k + 1;
			end
			hit = eligible && (int'(len) == n);
			for (int j = 0; j < KW_TEXT_BYTES; j++) begin
				if (j < n && text[j] != KW_TEXT[i][8*(n-1-j) +: 8]) hit = 1'b0;
			end
			if (hit && !found) begin
				found = 1'b1;
				cls = CLASS_KW_BASE + 7'(i);
			end
		end
		return cls;
	endfunction

endpackage
`default_nettype wire

// File: hdl/sst_lexer.sv
// Tokenizer state registers and the per-byte scanning logic.
`default_nettype none
module sst_lexer #(
	parameter int POSITION_WIDTH = 32,
	parameter int KEYWORD_MAX_LEN = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sst_pkg::src_item_t item,
	input  wire logic               fire,
	input  wire logic [31:0]        start_line,
	input  wire logic [31:0]        start_offset,
	output sst_pkg::tok_item_t      res0,
	output sst_pkg::tok_item_t      res1,
	output logic [1:0]              res_count
);
	import sst_pkg::*;

	localparam int PW = POSITION_WIDTH;

	lex_mode_t       mode_q, mode_d;
	logic [31:0]     line_q, line_d;
	logic [PW-1:0]   pos_q, pos_d;
	logic [PW-1:0]   tbegin_q, tbegin_d;
	logic [31:0]     tlen_q, tlen_d;
	logic            after_cr_q, after_cr_d;
	logic [7:0]      pend_q, pend_d;
	logic [7:0]      prefix_q [KEYWORD_MAX_LEN];
	logic [7:0]      prefix_d [KEYWORD_MAX_LEN];
	logic            overlong_q, overlong_d;
	logic            halted_q, halted_d;
	logic            fresh_q, fresh_d;

	logic [KW_TEXT_BYTES-1:0][7:0] kw_text_in;
	logic [6:0]                    name_cls;

	always_comb begin
		for (int j = 0; j < KW_TEXT_BYTES; j++) kw_text_in[j] = prefix_q[j];
	end

	assign name_cls = kw_class(kw_text_in, tlen_q[3:0],
		!overlong_q && (tlen_q <= 32'(KEYWORD_MAX_LEN)) && (tlen_q <= 32'(KW_TEXT_BYTES)));

	always_comb begin
		tok_item_t   res_c [2];
		logic [1:0]  cnt;
		logic [7:0]  b;
		logic [31:0] line;
		logic [PW-1:0] pos;
		logic        do_start;
		logic [5:0]  pc;
		logic [7:0]  ch;
		logic        ch_ok;

		res_c[0] = '0;
		res_c[1] = '0;
		cnt = 2'd0;
		b = item.data_byte;
		line = fresh_q ? start_line : line_q;
		pos = fresh_q ? PW'(start_offset) : pos_q;
		do_start = 1'b0;
		ch = 8'd0;
		ch_ok = 1'b0;

		mode_d = mode_q;
		tbegin_d = tbegin_q;
		tlen_d = tlen_q;
		after_cr_d = after_cr_q;
		pend_d = pend_q;
		prefix_d = prefix_q;
		overlong_d = overlong_q;
		halted_d = halted_q;
		fresh_d = 1'b0;
		line_d = line;
		pos_d = pos;

		if (item.op == OP_BYTE) begin
			if (!halted_q) begin
				unique case (mode_q)
					MODE_PUNCT: begin
						pc = punct_pair(pend_q, b);
						if (pend_q == "/" && b == "/") begin
							mode_d = MODE_LINE;
						end else if (pend_q == "/" && b == "*") begin
							mode_d = MODE_BLOCK;
						end else if (pc != PUNCT_NONE) begin
							if (tlen_d != '1) tlen_d = tlen_d + 32'd1;
							res_c[cnt[0]] = make_res(KIND_TOKEN, CLASS_PUNCT, pc,
								32'(tbegin_d), tlen_d, line, ERR_NONE, 8'd0);
							cnt = cnt + 2'd1;
							mode_d = MODE_IDLE;
						end else begin
							res_c[cnt[0]] = make_res(KIND_TOKEN, CLASS_PUNCT,
								punct_single(pend_q), 32'(tbegin_d), tlen_d, line,
								ERR_NONE, 8'd0);
							cnt = cnt + 2'd1;
							mode_d = MODE_IDLE;
							do_start = 1'b1;
						end
					end
					MODE_LINE: begin
						if (b == 8'h0D || b == 8'h0A) mode_d = MODE_IDLE;
					end
					MODE_BLOCK: begin
						if (b == "*") mode_d = MODE_STAR;
					end
					MODE_STAR: begin
						if (b == "/") mode_d = MODE_IDLE;
						else if (b != "*") mode_d = MODE_BLOCK;
					end
					MODE_NAME: begin
						if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
							b == "_" || (b >= "0" && b <= "9")) begin
							if (tlen_q < 32'(KEYWORD_MAX_LEN)) begin
								for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
									if (tlen_q == 32'(j)) prefix_d[j] = b;
								end
							end else begin
								overlong_d = 1'b1;
							end
							if (tlen_d != '1) tlen_d = tlen_d + 32'd1;
						end else begin
							res_c[cnt[0]] = make_res(KIND_TOKEN, name_cls, 6'd0,
								32'(tbegin_d), tlen_d, line, ERR_NONE, 8'd0);
							cnt = cnt + 2'd1;
							mode_d = MODE_IDLE;
							do_start = 1'b1;
						end
					end
					MODE_NUM, MODE_CARET: begin
						if ((b >= "0" && b <= "9") || b == "." || b == "f" || b == "^" ||
							(b == "-" && mode_q == MODE_CARET)) begin
							if (tlen_d != '1) tlen_d = tlen_d + 32'd1;
							mode_d = (b == "^") ? MODE_CARET : MODE_NUM;
						end else begin
							res_c[cnt[0]] = make_res(KIND_TOKEN, CLASS_NUMBER, 6'd0,
								32'(tbegin_d), tlen_d, line, ERR_NONE, 8'd0);
							cnt = cnt + 2'd1;
							mode_d = MODE_IDLE;
							do_start = 1'b1;
						end
					end
					MODE_STR: begin
						if (b == 8'h0D || b == 8'h0A) begin
							res_c[cnt[0]] = make_res(KIND_ERROR, CLASS_NAME, 6'd0,
								32'(pos), 32'd0, line, ERR_NEWLINE, 8'd0);
							cnt = cnt + 2'd1;
							halted_d = 1'b1;
							mode_d = MODE_IDLE;
						end else begin
							if (tlen_d != '1) tlen_d = tlen_d + 32'd1;
							if (b == "\"") begin
								res_c[cnt[0]] = make_res(KIND_TOKEN, CLASS_STRING, 6'd0,
									32'(tbegin_d), tlen_d, line, ERR_NONE, 8'd0);
								cnt = cnt + 2'd1;
								mode_d = MODE_IDLE;
							end else if (b == "\\") begin
								mode_d = MODE_ESC;
							end else begin
								res_c[cnt[0]] = make_res(KIND_CHAR, CLASS_STRING, 6'd0,
									32'(tbegin_d), 32'd0, line, ERR_NONE, b);
								cnt = cnt + 2'd1;
							end
						end
					end
					MODE_ESC: begin
						ch_ok = 1'b1;
						unique case (b)
							"n": ch = 8'h0A;
							"r": ch = 8'h0D;
							"t": ch = 8'h09;
							"\"": ch = "\"";
							"\\": ch = "\\";
							default: ch_ok = 1'b0;
						endcase
						if (ch_ok) begin
							if (tlen_d != '1) tlen_d = tlen_d + 32'd1;
							res_c[cnt[0]] = make_res(KIND_CHAR, CLASS_STRING, 6'd0,
								32'(tbegin_d), 32'd0, line, ERR_NONE, ch);
							cnt = cnt + 2'd1;
							mode_d = MODE_STR;
						end else begin
							res_c[cnt[0]] = make_res(KIND_ERROR, CLASS_NAME, 6'd0,
								32'(pos), 32'd0, line, ERR_ESCAPE, 8'd0);
							cnt = cnt + 2'd1;
							halted_d = 1'b1;
							mode_d = MODE_IDLE;
						end
					end
					default: begin
						mode_d = MODE_IDLE;
						do_start = 1'b1;
					end
				endcase

				// The byte that ended a token may itself open the next one.
				if (do_start && b > 8'h20) begin
					tbegin_d = pos;
					tlen_d = 32'd1;
					pc = punct_single(b);
					if (b == "\"") begin
						mode_d = MODE_STR;
					end else if (b >= "0" && b <= "9") begin
						mode_d = MODE_NUM;
					end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
						b == "_") begin
						mode_d = MODE_NAME;
						prefix_d[0] = b;
						overlong_d = 1'b0;
					end else if (pc == PUNCT_NONE) begin
						res_c[cnt[0]] = make_res(KIND_ERROR, CLASS_NAME, 6'd0,
							32'(pos), 32'd0, line, ERR_SYMBOL, 8'd0);
						cnt = cnt + 2'd1;
						halted_d = 1'b1;
						mode_d = MODE_IDLE;
					end else if (pc <= PUNCT_LAST_PAIRABLE) begin
						pend_d = b;
						mode_d = MODE_PUNCT;
					end else begin
						res_c[cnt[0]] = make_res(KIND_TOKEN, CLASS_PUNCT, pc,
							32'(tbegin_d), tlen_d, line, ERR_NONE, 8'd0);
						cnt = cnt + 2'd1;
						mode_d = MODE_IDLE;
					end
				end
			end
			if (b == 8'h0D || (b == 8'h0A && !after_cr_q)) line_d = line + 32'd1;
			after_cr_d = (b == 8'h0D);
			pos_d = pos + PW'(1);
		end else begin
			if (!halted_q) begin
				unique case (mode_q)
					MODE_PUNCT: begin
						res_c[cnt[0]] = make_res(KIND_TOKEN, CLASS_PUNCT,
							punct_single(pend_q), 32'(tbegin_q), tlen_q, line,
							ERR_NONE, 8'd0);
						cnt = cnt + 2'd1;
					end
					MODE_NAME: begin
						res_c[cnt[0]] = make_res(KIND_TOKEN, name_cls, 6'd0,
							32'(tbegin_q), tlen_q, line, ERR_NONE, 8'd0);
						cnt = cnt + 2'd1;
					end
					MODE_NUM, MODE_CARET: begin
						res_c[cnt[0]] = make_res(KIND_TOKEN, CLASS_NUMBER, 6'd0,
							32'(tbegin_q), tlen_q, line, ERR_NONE, 8'd0);
						cnt = cnt + 2'd1;
					end
					MODE_BLOCK, MODE_STAR, MODE_STR, MODE_ESC: begin
						res_c[cnt[0]] = make_res(KIND_ERROR, CLASS_NAME, 6'd0,
							32'(pos), 32'd0, line, ERR_UNEXPECTED, 8'd0);
						cnt = cnt + 2'd1;
					end
					default: ;
				endcase
			end
			res_c[cnt[0]] = make_res(KIND_END, CLASS_NAME, 6'd0, 32'(pos), 32'd0,
				line, ERR_NONE, 8'd0);
			cnt = cnt + 2'd1;
			mode_d = MODE_IDLE;
			tbegin_d = '0;
			tlen_d = 32'd0;
			after_cr_d = 1'b0;
			pend_d = 8'd0;
			overlong_d = 1'b0;
			halted_d = 1'b0;
			fresh_d = 1'b1;
		end

		if (cnt == 2'd1) res_c[0].last_of_run = 1'b1;
		else if (cnt == 2'd2) res_c[1].last_of_run = 1'b1;

		res0 = res_c[0];
		res1 = res_c[1];
		res_count = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= 32'd0;
			pos_q <= '0;
			tbegin_q <= '0;
			tlen_q <= 32'd0;
			after_cr_q <= 1'b0;
			pend_q <= 8'd0;
			overlong_q <= 1'b0;
			halted_q <= 1'b0;
			fresh_q <= 1'b1;
		end else if (fire) begin
			mode_q <= mode_d;
			line_q <= line_d;
			pos_q <= pos_d;
			tbegin_q <= tbegin_d;
			tlen_q <= tlen_d;
			after_cr_q <= after_cr_d;
			pend_q <= pend_d;
			overlong_q <= overlong_d;
			halted_q <= halted_d;
			fresh_q <= fresh_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) prefix_q <= prefix_d;
	end

endmodule
`default_nettype wire

// File: hdl/sst_result_queue.sv
// Two-entry result queue between the scanning logic and the token channel.
`default_nettype none
module sst_result_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic [1:0]         push_count,
	input  wire sst_pkg::tok_item_t push0,
	input  wire sst_pkg::tok_item_t push1,
	output logic                    free,
	output logic                    valid,
	input  wire logic               ready,
	output sst_pkg::tok_item_t      head
);
	import sst_pkg::*;

	tok_item_t  slot0_q, slot1_q;
	logic [1:0] count_q;
	logic       pop;

	assign valid = (count_q != 2'd0);
	assign pop = valid && ready;
	assign head = slot0_q;
	// New results may enter once everything still queued leaves this cycle.
	assign free = (count_q == 2'd0) || (count_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && free) begin
			count_q <= push_count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && free) begin
			slot0_q <= push0;
			slot1_q <= push1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule
`default_nettype wire

// File: hdl/script_source_tokenizer.sv
// Top level of the script source tokenizer: input register, configuration and result queue.
`default_nettype none
// Streaming tokenizer: one source byte (or an end-of-input mark) per src transaction is
// taken into an input register and scanned combinationally, so bytes flow at one per
// cycle while each produces at most one result and tok_ready stays high. Some items
// produce two results: a byte that ends one token and at once opens a one-character
// token or raises an error, and an end-of-input mark that closes a pending token or
// reports an unexpected end. These two results fill the two-entry result queue, which
// drains one per cycle while tok_ready is high. A following item that produces results
// therefore waits in the input register until the one queued result is leaving.
// Registers start_line and start_offset take effect at the start of the next stream.
module script_source_tokenizer #(
	parameter int POSITION_WIDTH = 32,
	parameter int KEYWORD_MAX_LEN = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               src_valid,
	output logic                    src_ready,
	input  wire sst_pkg::src_item_t src_item,
	output logic                    tok_valid,
	input  wire logic               tok_ready,
	output sst_pkg::tok_item_t      tok_item,
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import sst_pkg::*;

	logic [31:0] start_line_val_q;
	logic [31:0] start_offset_q;
	src_item_t   item_s1;
	logic        valid_s1;
	tok_item_t   res0, res1;
	logic [1:0]  res_count;
	logic        q_free;
	logic        xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_line_val_q <= 32'd1;
			start_offset_q <= 32'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_START_LINE: start_line_val_q <= cfg_data;
				REG_START_OFFSET: start_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign xfer = valid_s1 && (res_count == 2'd0 || q_free);
	assign src_ready = !valid_s1 || xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && src_ready) begin
			valid_s1 <= 1'b1;
		end else if (xfer) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) item_s1 <= src_item;
	end

	sst_lexer #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
	) u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_s1),
		.fire(xfer),
		.start_line(start_line_val_q),
		.start_offset(start_offset_q),
		.res0(res0),
		.res1(res1),
		.res_count(res_count)
	);

	sst_result_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(xfer && res_count != 2'd0),
		.push_count(res_count),
		.push0(res0),
		.push1(res1),
		.free(q_free),
		.valid(tok_valid),
		.ready(tok_ready),
		.head(tok_item)
	);

`ifndef NO_ASSERTIONS
	// An end-of-input transaction always produces at least the end-of-stream result.
	a_end_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.op == OP_END |-> res_count != 2'd0)
		else $error("end of input produced no result");

	// The end-of-stream result is always the last one of its run.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.result_kind == KIND_END |-> tok_item.last_of_run)
		else $error("end of stream not marked last");

	// Results are only moved into the queue when nothing queued would be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && res_count != 2'd0 |-> q_free)
		else $error("queued result overwritten");
`endif

endmodule
`default_nettype wire
